// File: hw/rtl/mmhq_pkg.sv
// ============================================================================
// mmhq_pkg
// Shared types and codes for the min/max priority queue and its key cells.
// ============================================================================
package mmhq_pkg;

   // Request kinds carried by an input item.
   typedef enum logic [1:0] {
      KIND_INSERT  = 2'd0,
      KIND_DEL_MIN = 2'd1,
      KIND_DEL_MAX = 2'd2,
      KIND_QUERY   = 2'd3
   } kind_type;

   // Status codes returned with every result item.
   typedef enum logic [1:0] {
      STATUS_DONE     = 2'd0,
      STATUS_OVERFLOW = 2'd1,
      STATUS_EMPTY    = 2'd2
   } status_type;

   // Operation that every cell of the sorted chain applies at once.
   typedef enum logic [1:0] {
      OP_HOLD     = 2'd0,
      OP_INSERT   = 2'd1,
      OP_POP_LOW  = 2'd2,
      OP_POP_HIGH = 2'd3
   } cell_op_type;

   // Broadcast control for the chain.
   typedef struct packed {
      cell_op_type        op;
      logic signed [31:0] key;
   } cell_ctrl_type;

   localparam logic signed [31:0] KEY_LARGEST  = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] KEY_SMALLEST = 32'sh8000_0000;

endpackage

// File: hw/rtl/mmhq_cell.sv
// ============================================================================
// mmhq_cell
// One slot of the sorted key chain. Keys are kept in ascending order from the
// first cell, valid slots packed at the low end.
// ============================================================================
module mmhq_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  mmhq_pkg::cell_ctrl_type ctrl,
   input  logic signed [31:0]     left_key,
   input  logic                   left_valid,
   input  logic                   left_gt,
   input  logic signed [31:0]     right_key,
   input  logic                   right_valid,
   output logic signed [31:0]     key,
   output logic                   valid,
   output logic                   gt
);
   import mmhq_pkg::*;

   logic signed [31:0] key_ff;
   logic signed [31:0] key_in;
   logic               valid_ff;
   logic               valid_in;

   // This slot must move up for the broadcast key when it is empty or larger.
   assign gt    = !valid_ff || (key_ff > ctrl.key);
   assign key   = key_ff;
   assign valid = valid_ff;

   // Next slot contents for the broadcast operation.
   always_comb begin
      key_in   = key_ff;
      valid_in = valid_ff;
      unique case (ctrl.op)
         OP_HOLD: begin
         end
         OP_INSERT: begin
            if (gt) begin
               if (!left_gt) begin
                  key_in   = ctrl.key;
                  valid_in = 1'b1;
               end else begin
                  key_in   = left_key;
                  valid_in = left_valid;
               end
            end
         end
         OP_POP_LOW: begin
            key_in   = right_key;
            valid_in = right_valid;
         end
         OP_POP_HIGH: begin
            valid_in = valid_ff && right_valid;
         end
         default: begin
         end
      endcase
   end

   // Occupancy flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Key payload.
   always_ff @(posedge clock) begin
      key_ff <= key_in;
   end

endmodule

// File: hw/rtl/min_max_heap_queue.sv
// An accepted item steps through the apply, group and final states, and its
// result item is registered on leaving the final state, which waits while the
// result register is stalled. No new item is taken until then. The chain update
// is followed by the two-stage registered search for the highest occupied cell.
// Every kind of item costs the same. Reset empties the queue at once: cell valid
// bits and the count clear together, there is no clearing pass.
// ============================================================================
// min_max_heap_queue
// Double-ended priority queue of signed keys held in a sorted chain of cells.
// ============================================================================
module min_max_heap_queue #(
   parameter int CAPACITY = 128
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [1:0]           req_kind,
   input  logic signed [31:0]   req_key,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic signed [31:0]   rsp_min_value,
   output logic signed [31:0]   rsp_max_value,
   output logic [7:0]           rsp_count,
   output logic [1:0]           rsp_status
);
   import mmhq_pkg::*;

   localparam int CW   = $clog2(CAPACITY + 1);
   localparam int GRP  = 16;
   localparam int NGRP = (CAPACITY + GRP - 1) / GRP;
   localparam logic [CW-1:0] CNT_FULL = CW'(CAPACITY);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_APPLY = 4'b0010,
      ST_GROUP = 4'b0100,
      ST_FINAL = 4'b1000
   } state_type;

   state_type          state_ff;
   state_type          state_in;
   cell_op_type        op_ff;
   logic signed [31:0] key_ff;
   status_type         status_ff;
   logic [CW-1:0]      count_ff;
   logic [CW-1:0]      count_in;
   cell_ctrl_type      cell_ctrl;

   logic signed [31:0] key_w   [CAPACITY];
   logic               valid_w [CAPACITY];
   logic               gt_w    [CAPACITY];
   logic signed [31:0] pick_w  [NGRP*GRP];
   logic signed [31:0] grp_w   [NGRP];
   logic signed [31:0] grp_ff  [NGRP];
   logic signed [31:0] top_w;

   logic               rsp_valid_ff;
   logic signed [31:0] rsp_min_ff;
   logic signed [31:0] rsp_max_ff;
   logic [CW-1:0]      rsp_count_ff;
   status_type         rsp_status_ff;
   logic [31:0]        cnt_ext;
   logic               out_free;

   logic               accept;
   kind_type           kind_w;

   assign accept   = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign kind_w   = kind_type'(req_kind);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Sequencer for one item.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (req_valid) state_in = ST_APPLY;
         ST_APPLY: state_in = ST_GROUP;
         ST_GROUP: state_in = ST_FINAL;
         ST_FINAL: if (out_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // Count follows the chain operation.
   always_comb begin
      count_in = count_ff;
      if (state_ff == ST_APPLY) begin
         case (op_ff) inside
            OP_INSERT:               count_in = count_ff + CW'(1);
            OP_POP_LOW, OP_POP_HIGH: count_in = count_ff - CW'(1);
            default:                 count_in = count_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   // Decode the item into a chain operation and a status at acceptance.
   always_ff @(posedge clock) begin
      if (reset) begin
         op_ff     <= OP_HOLD;
         status_ff <= STATUS_DONE;
      end else if (accept) begin
         op_ff     <= OP_HOLD;
         status_ff <= STATUS_DONE;
         unique case (kind_w)
            KIND_INSERT: begin
               if (count_ff == CNT_FULL) status_ff <= STATUS_OVERFLOW;
               else op_ff <= OP_INSERT;
            end
            KIND_DEL_MIN: begin
               if (count_ff == '0) status_ff <= STATUS_EMPTY;
               else op_ff <= OP_POP_LOW;
            end
            KIND_DEL_MAX: begin
               if (count_ff == '0) status_ff <= STATUS_EMPTY;
               else op_ff <= OP_POP_HIGH;
            end
            KIND_QUERY: begin
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (accept) key_ff <= req_key;
   end

   // The chain acts only in the apply cycle.
   always_comb begin
      cell_ctrl.op  = (state_ff == ST_APPLY) ? op_ff : OP_HOLD;
      cell_ctrl.key = key_ff;
   end

   // Chain of cells, ascending from cell zero.
   genvar i;
   generate
      for (i = 0; i < CAPACITY; i++) begin : g_cell
         logic signed [31:0] lk;
         logic               lv;
         logic               lg;
         logic signed [31:0] rk;
         logic               rv;
         if (i == 0) begin : g_first
            assign lk = '0;
            assign lv = 1'b0;
            assign lg = 1'b0;
         end else begin : g_mid_l
            assign lk = key_w[i-1];
            assign lv = valid_w[i-1];
            assign lg = gt_w[i-1];
         end
         if (i == CAPACITY - 1) begin : g_last
            assign rk = '0;
            assign rv = 1'b0;
         end else begin : g_mid_r
            assign rk = key_w[i+1];
            assign rv = valid_w[i+1];
         end
         mmhq_cell u_cell (
            .clock       (clock),
            .reset       (reset),
            .ctrl        (cell_ctrl),
            .left_key    (lk),
            .left_valid  (lv),
            .left_gt     (lg),
            .right_key   (rk),
            .right_valid (rv),
            .key         (key_w[i]),
            .valid       (valid_w[i]),
            .gt          (gt_w[i])
         );
         // The highest occupied cell holds the largest key.
         assign pick_w[i] = (valid_w[i] && !rv) ? key_w[i] : '0;
      end
      for (i = CAPACITY; i < NGRP*GRP; i++) begin : g_pad
         assign pick_w[i] = '0;
      end
   endgenerate

   // First level of the search: one OR per group of cells.
   always_comb begin
      for (int g = 0; g < NGRP; g++) begin
         grp_w[g] = '0;
         for (int j = 0; j < GRP; j++) begin
            grp_w[g] = grp_w[g] | pick_w[g*GRP + j];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_GROUP) begin
         for (int g = 0; g < NGRP; g++) grp_ff[g] <= grp_w[g];
      end
   end

   // Second level over the group results.
   always_comb begin
      top_w = '0;
      for (int g = 0; g < NGRP; g++) top_w = top_w | grp_ff[g];
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == ST_FINAL && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_FINAL && out_free) begin
         rsp_min_ff    <= (count_ff == '0) ? KEY_LARGEST : key_w[0];
         rsp_max_ff    <= (count_ff == '0) ? KEY_SMALLEST : top_w;
         rsp_count_ff  <= count_ff;
         rsp_status_ff <= status_ff;
      end
   end

   assign cnt_ext       = 32'(rsp_count_ff);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_min_value = rsp_min_ff;
   assign rsp_max_value = rsp_max_ff;
   assign rsp_count     = cnt_ext[7:0];
   assign rsp_status    = rsp_status_ff;

`ifndef SYNTH
   // The count never passes the capacity.
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_FULL)
      else $error("key count above capacity");

   // A nonempty result has its minimum no larger than its maximum.
   a_min_le_max: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_count_ff != '0) |-> (rsp_min_ff <= rsp_max_ff))
      else $error("minimum above maximum");

   // An overflow result reports a full queue.
   a_overflow_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == STATUS_OVERFLOW) |-> (rsp_count_ff == CNT_FULL))
      else $error("overflow without a full queue");

   // Outside an accepted item, cell zero's valid bit does not change.
   a_cell0_stable: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && !accept) |=> $stable(valid_w[0]))
      else $error("chain changed outside an item");
`endif

endmodule

// File: test/tb.sv
// ============================================================================
// tb
// Testbench for min_max_heap_queue. It drives random and directed queue
// requests in bursts, stalls the result side in changing patterns, and checks
// every result item against a software model of a double-ended queue.
// ============================================================================
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import mmhq_pkg::*;

   localparam int CAPACITY   = 128;
   localparam int RANDOM_OPS = 1050;

   typedef struct {
      kind_type           kind;
      logic signed [31:0] key;
      bit                 drain_first;
   } request_type;

   typedef struct {
      logic signed [31:0] min_value;
      logic signed [31:0] max_value;
      logic [7:0]         count;
      status_type         status;
   } summary_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [1:0]          req_kind = '0;
   logic signed [31:0]  req_key = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic signed [31:0]  rsp_min_value;
   logic signed [31:0]  rsp_max_value;
   logic [7:0]          rsp_count;
   logic [1:0]          rsp_status;

   request_type         pending_requests[$];
   summary_type         expected_summaries[$];
   logic signed [31:0]  held_keys[$];
   int                  error_count = 0;

   min_max_heap_queue #(.CAPACITY(CAPACITY)) DUT (.*);

   always #5 clock = ~clock;

   // Prints one mismatch line and counts it.
   task automatic report(input string what, input longint got, input longint want);
      $display("ERROR %0t: %s got %0d expected %0d", $realtime, what, got, want);
      error_count++;
   endtask

   // Applies one request to the key multiset and returns the summary it causes.
   function automatic summary_type apply_request(input request_type r);
      summary_type s;
      int          pick;
      s.status = STATUS_DONE;
      case (r.kind) inside
         KIND_INSERT: begin
            if (held_keys.size() >= CAPACITY) s.status = STATUS_OVERFLOW;
            else held_keys.push_back(r.key);
         end
         KIND_DEL_MIN, KIND_DEL_MAX: begin
            if (held_keys.size() == 0) begin
               s.status = STATUS_EMPTY;
            end else begin
               pick = 0;
               foreach (held_keys[i]) begin
                  if (r.kind == KIND_DEL_MIN ? held_keys[i] < held_keys[pick]
                                             : held_keys[i] > held_keys[pick])
                     pick = i;
               end
               held_keys.delete(pick);
            end
         end
         default: ;
      endcase
      s.min_value = KEY_LARGEST;
      s.max_value = KEY_SMALLEST;
      foreach (held_keys[i]) begin
         if (held_keys[i] < s.min_value) s.min_value = held_keys[i];
         if (held_keys[i] > s.max_value) s.max_value = held_keys[i];
      end
      s.count = 8'(held_keys.size());
      return s;
   endfunction

   // Keys lean toward the extremes and a narrow band so that ties are common.
   function automatic logic signed [31:0] pick_key();
      case ($urandom_range(0, 9)) inside
         0: return KEY_LARGEST;
         1: return KEY_SMALLEST;
         2, 3, 4: return $signed($urandom_range(0, 8)) - 4;
         default: return $urandom;
      endcase
   endfunction

   function automatic void queue_request(input kind_type k, input logic signed [31:0] key,
                                         input bit drain_first = 1'b0);
      request_type r;
      r.kind = k;
      r.key = key;
      r.drain_first = drain_first;
      pending_requests.push_back(r);
   endfunction

   // Sender: bursts of random length with random gaps; a marked item waits
   // until every expected result has come back.
   int          burst_left = 0;
   int          gap_left = 0;
   request_type current;
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) expected_summaries.push_back(apply_request(current));
         if (!(req_valid && req_stall)) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_requests.size() == 0 ||
                         (pending_requests[0].drain_first && expected_summaries.size() > 0))
            begin
               req_valid <= 1'b0;
            end else begin
               current = pending_requests.pop_front();
               req_kind <= current.kind;
               req_key <= current.key;
               req_valid <= 1'b1;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(0, 40);
                  gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
               end
            end
         end
      end
   end

   // Receiver: the stall pattern is redrawn at intervals, with one long hold-off.
   int cycle_count = 0;
   int stall_mode = 0;
   int hold_left = 0;
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count % 64 == 0) stall_mode = $urandom_range(0, 3);
      if (cycle_count == 3000) hold_left = 400;
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 1) == 0);
            2: rsp_stall <= (cycle_count % 4 != 0);
            default: rsp_stall <= ($urandom_range(0, 7) == 0);
         endcase
      end
   end

   // Monitor: each accepted result is checked against the oldest expectation.
   summary_type want;
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_summaries.size() == 0) begin
            report("result item with none expected, count", rsp_count, 0);
         end else begin
            want = expected_summaries.pop_front();
            if (rsp_min_value !== want.min_value)
               report("min_value", rsp_min_value, want.min_value);
            if (rsp_max_value !== want.max_value)
               report("max_value", rsp_max_value, want.max_value);
            if (rsp_count !== want.count) report("count", rsp_count, want.count);
            if (rsp_status !== want.status) report("status", rsp_status, want.status);
         end
      end
   end

   // Stimulus and end of run.
   initial begin
      int fill;
      int roll;
      // Directed: empty removals, extremes, ties, every kind.
      queue_request(KIND_QUERY, 32'sd0);
      queue_request(KIND_DEL_MIN, 32'sd0);
      queue_request(KIND_DEL_MAX, 32'sd0);
      queue_request(KIND_INSERT, KEY_LARGEST);
      queue_request(KIND_DEL_MAX, 32'sd0);
      queue_request(KIND_INSERT, KEY_SMALLEST);
      queue_request(KIND_DEL_MIN, 32'sd0);
      queue_request(KIND_INSERT, KEY_LARGEST);
      queue_request(KIND_INSERT, KEY_SMALLEST);
      queue_request(KIND_INSERT, 32'sd0);
      queue_request(KIND_INSERT, -32'sd1);
      queue_request(KIND_INSERT, 32'sd5);
      queue_request(KIND_INSERT, 32'sd5);
      queue_request(KIND_INSERT, 32'sd5);
      queue_request(KIND_QUERY, 32'h5555_5555);
      queue_request(KIND_DEL_MAX, 32'sd0);
      queue_request(KIND_DEL_MIN, 32'sd0);
      queue_request(KIND_DEL_MAX, 32'sd0);
      queue_request(KIND_DEL_MIN, 32'sd0);
      queue_request(KIND_DEL_MIN, 32'sd0);
      queue_request(KIND_DEL_MAX, 32'sd0);
      queue_request(KIND_DEL_MIN, 32'sd0);
      queue_request(KIND_QUERY, 32'hAAAA_AAAA, 1'b1);

      // Random: fill past capacity, drain past empty, and mixed stretches.
      fill = 0;
      while (pending_requests.size() < RANDOM_OPS) begin
         roll = $urandom_range(0, 5);
         if (roll == 0) begin
            repeat (CAPACITY + 4 - fill) queue_request(KIND_INSERT, pick_key());
            repeat ($urandom_range(1, 5)) queue_request(kind_type'($urandom_range(0, 3)), 0);
            repeat (CAPACITY + 3)
               queue_request(kind_type'($urandom_range(0, 1) ? KIND_DEL_MIN : KIND_DEL_MAX),
                             0);
            fill = 0;
         end else begin
            repeat (60) begin
               request_type r;
               r.kind = kind_type'(($urandom_range(0, 9) < 5) ? KIND_INSERT
                                                              : $urandom_range(1, 3));
               r.key = (r.kind == KIND_INSERT) ? pick_key() : $urandom;
               r.drain_first = ($urandom_range(0, 200) == 0);
               if (r.kind == KIND_INSERT && fill < CAPACITY) fill++;
               else if ((r.kind == KIND_DEL_MIN || r.kind == KIND_DEL_MAX) && fill > 0) fill--;
               pending_requests.push_back(r);
            end
         end
      end

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      wait (pending_requests.size() == 0 && !req_valid && expected_summaries.size() == 0);
      repeat (20) @(posedge clock);
      if (error_count == 0 && expected_summaries.size() == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

   // Watchdog.
   initial begin
      #5ms;
      $display("tb NOT OK");
      $finish;
   end

endmodule
